>>> rtl/core/lfu_slot_replacement_top_macros.svh
// Assertion macros shared by the slot table modules.
// No dependencies; included by the files that carry assertions.
`ifndef LFU_SLOT_REPLACEMENT_TOP_MACROS_SVH
`define LFU_SLOT_REPLACEMENT_TOP_MACROS_SVH
`ifndef SYNTH
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/lfu_pkg.sv
// Shared types for the LFU slot table: controller states and commands.
// No dependencies.
package lfu_pkg;
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_OUTPUT = 3'b100
    } lfu_state_t;

    typedef struct packed {
        logic capture;
        logic update;
    } lfu_cmd_t;
endpackage

>>> rtl/core/lfu_ctrl.sv
// Controller state machine for the LFU slot table.
// Depends on lfu_pkg and the assertion macro header.
`include "lfu_slot_replacement_top_macros.svh"
module lfu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lfu_pkg::lfu_cmd_t   cmd
);
    import lfu_pkg::*;

    lfu_state_t state_reg, state_next;

    // Capture an item when idle or as the result leaves, update the table next, then hold the result.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_OUTPUT;
            ST_OUTPUT: if (out_ready) state_next = in_valid ? ST_UPDATE : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    // A new transaction is taken as soon as the previous result leaves.
    assign in_ready    = (state_reg == ST_IDLE) || (state_reg == ST_OUTPUT && out_ready);
    assign out_valid   = (state_reg == ST_OUTPUT);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.update  = (state_reg == ST_UPDATE);

    `LFU_ASSERT_NXT(a_cap_upd, clk, rst_n, cmd.capture, cmd.update, "capture not followed by update")
    `LFU_ASSERT_NXT(a_upd_out, clk, rst_n, cmd.update, out_valid, "update not followed by result")
    `LFU_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
endmodule

>>> rtl/core/lfu_dpath.sv
// Datapath of the LFU slot table: slot registers, match, minimum search, shift.
// Depends on lfu_pkg and the assertion macro header.
`include "lfu_slot_replacement_top_macros.svh"
module lfu_dpath #(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 8,
    parameter int VOTE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfu_pkg::lfu_cmd_t    cmd,
    input  logic [4:0]           active_slots,
    input  logic [ID_BITS-1:0]   candidate,
    output logic                 hit,
    output logic                 evicted,
    output logic [ID_BITS-1:0]   evicted_id,
    output logic [VOTE_BITS-1:0] votes_now
);
    import lfu_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int P2 = 1 << IW;
    localparam logic [VOTE_BITS-1:0] VMAX = {VOTE_BITS{1'b1}};

    logic [ID_BITS-1:0]   ident_reg [SLOTS];
    logic [VOTE_BITS-1:0] votes_reg [SLOTS];
    logic [CW-1:0]        filled_reg;
    logic [ID_BITS-1:0]   cand_reg;
    logic [CW-1:0]        limit_reg;
    logic [SLOTS-1:0]     match_reg;
    logic [IW-1:0]        pick_reg;
    logic                 hit_reg, evicted_reg;
    logic [ID_BITS-1:0]   evid_reg;
    logic [VOTE_BITS-1:0] vnow_reg;

    logic [SLOTS-1:0]     match;
    logic [IW-1:0]        pick;
    logic [CW-1:0]        limit;
    logic [5:0]           lim6;
    logic [VOTE_BITS-1:0] hit_votes;
    logic                 is_hit;
    logic                 is_append;

    logic [VOTE_BITS-1:0] node_votes [1:2*P2-1];
    logic [IW-1:0]        node_idx   [1:2*P2-1];
    logic                 node_used  [1:2*P2-1];

    // Effective slot count: register clamped to one..SLOTS.
    always_comb
    begin
        lim6 = {1'b0, active_slots};
        if (lim6 == 6'd0) lim6 = 6'd1;
        if (32'(lim6) > SLOTS) limit = CW'(SLOTS);
        else limit = CW'(lim6);
    end

    // Per-slot compare against the incoming identifier, registered on acceptance.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            match[i] = (CW'(i) < filled_reg) && (ident_reg[i] == candidate);
    end

    // Oldest least-voted slot among the filled entries, found by a balanced tree.
    // On equal counts the lower (older) side wins.
    always_comb
    begin
        for (int i = 0; i < P2; i++)
        begin
            node_idx[P2 + i]   = IW'(i);
            node_used[P2 + i]  = (i < SLOTS) && (CW'(i) < filled_reg);
            node_votes[P2 + i] = (i < SLOTS) ? votes_reg[i % SLOTS] : '0;
        end
        for (int n = P2 - 1; n >= 1; n--)
        begin
            if (node_used[2*n + 1] && (node_votes[2*n + 1] < node_votes[2*n]))
            begin
                node_votes[n] = node_votes[2*n + 1];
                node_idx[n]   = node_idx[2*n + 1];
            end
            else
            begin
                node_votes[n] = node_votes[2*n];
                node_idx[n]   = node_idx[2*n];
            end
            node_used[n] = node_used[2*n] || node_used[2*n + 1];
        end
        pick = node_idx[1];
    end

    // Count held by the matching slot, if any.
    always_comb
    begin
        hit_votes = '0;
        for (int i = 0; i < SLOTS; i++)
            if (match_reg[i])
                hit_votes = hit_votes | votes_reg[i];
    end

    assign is_hit    = |match_reg;
    assign is_append = (filled_reg < limit_reg);

    // Capture stage: register the candidate, the limit and the compare result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cand_reg  <= candidate;
            limit_reg <= limit;
            match_reg <= match;
        end
    end

    // The table is stable outside the update edge, so the search result is
    // always current by the time it is used.
    always_ff @(posedge clk)
    begin
        pick_reg <= pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) filled_reg <= '0;
        else if (cmd.update && !is_hit && is_append)
            filled_reg <= filled_reg + 1'b1;
    end

    // Update stage: increment on a hit, append, or evict and shift.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (is_hit)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (match_reg[i] && votes_reg[i] != VMAX)
                        votes_reg[i] <= votes_reg[i] + 1'b1;
            end
            else if (is_append)
            begin
                ident_reg[filled_reg[IW-1:0]] <= cand_reg;
                votes_reg[filled_reg[IW-1:0]] <= VOTE_BITS'(1);
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (CW'(i) + 1'b1 == filled_reg)
                    begin
                        ident_reg[i] <= cand_reg;
                        votes_reg[i] <= VOTE_BITS'(1);
                    end
                    else if (IW'(i) >= pick_reg && CW'(i) + 1'b1 < filled_reg && i + 1 < SLOTS)
                    begin
                        ident_reg[i] <= ident_reg[(i + 1) % SLOTS];
                        votes_reg[i] <= votes_reg[(i + 1) % SLOTS];
                    end
                end
            end
        end
    end

    // Result registers, loaded on the update edge.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg     <= is_hit;
            evicted_reg <= !is_hit && !is_append;
            evid_reg    <= (!is_hit && !is_append) ? ident_reg[pick_reg] : '0;
            vnow_reg    <= !is_hit ? VOTE_BITS'(1) :
                           (hit_votes != VMAX) ? hit_votes + 1'b1 : VMAX;
        end
    end

    assign hit        = hit_reg;
    assign evicted    = evicted_reg;
    assign evicted_id = evid_reg;
    assign votes_now  = vnow_reg;

    `LFU_ASSERT_IMP(a_match1, clk, rst_n, cmd.update, $onehot0(match_reg), "id held twice")
    `LFU_ASSERT_IMP(a_fill, clk, rst_n, 1'b1, 32'(filled_reg) <= SLOTS, "fill beyond slots")
    `LFU_ASSERT_NXT(a_hitev, clk, rst_n, cmd.update, !(hit_reg && evicted_reg), "hit with eviction")
endmodule

>>> rtl/core/lfu_slot_replacement_top.sv
// Top level of the LFU slot table: configuration register, controller, datapath.
// Depends on lfu_pkg, lfu_ctrl and lfu_dpath.
//
//  channel   signals                        direction
//  input     in_valid, in_ready, candidate  in
//  output    out_valid, out_ready, results  out
//  config    cfg_we, cfg_wdata              in
//
// In each transaction the slot compare is registered at the accepting edge,
// and the slot registers are updated on the next edge.
// The result is presented from the cycle after the update and held until taken;
// the next item is accepted in the cycle the result leaves, and an output
// stall delays that acceptance.
// Reset empties the table and sets active_slots to 16.
module lfu_slot_replacement_top #(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 8,
    parameter int VOTE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ID_BITS-1:0]   candidate,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic                 evicted,
    output logic [ID_BITS-1:0]   evicted_id,
    output logic [VOTE_BITS-1:0] votes_now
);
    import lfu_pkg::*;

    lfu_cmd_t   cmd;
    logic [4:0] active_slots_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      active_slots_reg <= 5'd16;
        else if (cfg_we) active_slots_reg <= cfg_wdata;
    end

    lfu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
    );

    lfu_dpath #(.SLOTS(SLOTS), .ID_BITS(ID_BITS), .VOTE_BITS(VOTE_BITS)) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .active_slots(active_slots_reg),
        .candidate(candidate), .hit(hit), .evicted(evicted),
        .evicted_id(evicted_id), .votes_now(votes_now)
    );
endmodule
